[rtl/core/cpf_pkg.sv]
// cpf_pkg: shared widths, constants and register indexes of the current probe filter
// depends on nothing; imported by cpf_serial_div and current_probe_filter_trip_pwm

package cpf_pkg;

  // digit width of every serial datapath
  localparam int unsigned DIG_W = 4;

  // register and field widths
  localparam int unsigned GAIN_W = 24;
  localparam int unsigned OFS_W  = 20;
  localparam int unsigned PER_W  = 16;
  localparam int unsigned THR_W  = 19;
  localparam int unsigned CUR_W  = 20;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned OUT_W  = 40;

  // sample scaling: low part of the scaled sample handled digit by digit
  localparam int unsigned XL_W      = 12;
  localparam int unsigned XL_DIGITS = XL_W / DIG_W;

  // filter datapath
  localparam int unsigned FILT_W   = 24;
  localparam int unsigned SUM_W    = 28;
  localparam int unsigned MAG_W    = 27;
  localparam int unsigned FILT_DIV = 10;

  // compare datapath
  localparam int unsigned N_W         = 18;
  localparam int unsigned PMUL_W      = 20;
  localparam int unsigned PMUL_DIGITS = PMUL_W / DIG_W;
  localparam int unsigned PROD_W      = 36;
  localparam int unsigned SPAN_HALF   = 68000;
  localparam int unsigned SPAN_FULL   = 136000;

  // constant dividers
  localparam int unsigned DIV10_NUM_W = 24;
  localparam int unsigned DIV10_REM_W = 4;
  localparam int unsigned DIV2_NUM_W  = 20;
  localparam int unsigned DIV2_REM_W  = 18;

  localparam int unsigned CNT_W = 3;

  localparam int CUR_MIN = -524288;
  localparam int CUR_MAX = 524287;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_GAIN   = 2'd0;
  localparam logic [1:0] REG_OFFSET = 2'd1;
  localparam logic [1:0] REG_PERIOD = 2'd2;
  localparam logic [1:0] REG_THRESH = 2'd3;

endpackage

[rtl/core/cpf_serial_div.sv]
// cpf_serial_div: radix-16 restoring divider by a fixed constant, one digit per cycle
// depends on cpf_pkg (digit width)

module cpf_serial_div #(
  parameter int unsigned NumW    = 24,
  parameter int unsigned RemW    = 4,
  parameter int unsigned Divisor = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [RemW-1:0] rem_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);
  import cpf_pkg::*;

  localparam int unsigned Digits = NumW / DIG_W;
  localparam int unsigned CntW   = $clog2(Digits + 1);
  localparam logic [RemW:0] DivC = (RemW + 1)'(Divisor);

  logic [NumW-1:0] shreg_q, shreg_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [CntW-1:0] cnt_q;
  logic            done_q;

  // dividend bits leave at the top, quotient bits enter at the bottom
  always_comb begin
    logic [RemW:0] trial;
    shreg_d = shreg_q;
    rem_d   = rem_q;
    for (int i = 0; i < int'(DIG_W); i++) begin
      trial   = {rem_d, shreg_d[NumW-1]};
      shreg_d = shreg_d << 1;
      if (trial >= DivC) begin
        trial      = trial - DivC;
        shreg_d[0] = 1'b1;
      end
      rem_d = trial[RemW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CntW'(Digits);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == CntW'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shreg_q <= num_i;
      rem_q   <= rem_i;
    end else if (cnt_q != '0) begin
      shreg_q <= shreg_d;
      rem_q   <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = shreg_q;

endmodule

[rtl/core/current_probe_filter_trip_pwm.sv]
// current_probe_filter_trip_pwm: probe current scaling, 0.9/0.1 average, fire trip, pwm compare
// depends on cpf_pkg and cpf_serial_div
// a beat with run low goes straight to the output; with drive high the sample is scaled, offset
//   and saturated, then loads the filter if unloaded or is averaged in (divide by ten); every
//   running beat then maps the current through the compare multiply and divide; one item in
//   flight, next beat taken on return to idle while the finished beat waits in the output register
// reset: filter cleared and unloaded, registers at gain 0, offset 0, period 9999, threshold 64000

module current_probe_filter_trip_pwm #(
  parameter int unsigned ADC_BITS = 12,
  localparam int unsigned InW = ((ADC_BITS + 2 + 7) / 8) * 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [InW-1:0]              s_axis_tdata,   // run_wave, drive, adc_sample
  // result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [cpf_pkg::OUT_W-1:0]   m_axis_tdata,   // probe_current, scr_fire, duty_compare
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cpf_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import cpf_pkg::*;

  // scaled sample x = 2*adc - full, split as xh*4096 + xl
  localparam int unsigned XW  = (ADC_BITS + 1 > XL_W + 1) ? ADC_BITS + 1 : XL_W + 1;
  localparam int unsigned XHW = XW - XL_W;
  localparam int unsigned AW  = (XW + 13 > GAIN_W + DIG_W + 1) ? XW + 13 : GAIN_W + DIG_W + 1;
  localparam logic [XW-1:0] FullC = XW'((1 << ADC_BITS) - 1);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_MULH  = 4'd2;
  localparam logic [3:0] S_SAT   = 4'd3;
  localparam logic [3:0] S_ADD   = 4'd4;
  localparam logic [3:0] S_ABS   = 4'd5;
  localparam logic [3:0] S_DIV10 = 4'd6;
  localparam logic [3:0] S_CUR   = 4'd7;
  localparam logic [3:0] S_MUL2  = 4'd8;
  localparam logic [3:0] S_RND   = 4'd9;
  localparam logic [3:0] S_DIV2  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  // configuration registers
  logic signed [GAIN_W-1:0] gain_q;
  logic signed [OFS_W-1:0]  offset_q;
  logic [PER_W-1:0]         period_q;
  logic [THR_W-1:0]         thr_q;
  logic                     cfg_wr;
  logic [1:0]               cfg_idx;

  // control state
  logic [3:0]               state_q, state_d;
  logic [CNT_W-1:0]         dcnt_q, dcnt_d;
  logic                     loaded_q, loaded_d;
  logic signed [FILT_W-1:0] filt_q, filt_d;
  logic                     out_valid_q, out_valid_d;

  // datapath registers
  logic [XL_W-1:0]          xl_q, xl_d;
  logic signed [XHW-1:0]    xh_q, xh_d;
  logic signed [AW-1:0]     acc_q, acc_d;
  logic signed [SUM_W-1:0]  t9_q, t9_d;
  logic signed [CUR_W-1:0]  s_q, s_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic [CUR_W-1:0]         cur_q, cur_d;
  logic                     fire_q, fire_d;
  logic [N_W-1:0]           n_q, n_d;
  logic [PMUL_W-1:0]        pm_q, pm_d;
  logic [PROD_W-1:0]        acc2_q, acc2_d;
  logic [PER_W-1:0]         duty_q, duty_d;
  logic [OUT_W-1:0]         out_data_q, out_data_d;

  // input beat fields
  logic                     in_acc;
  logic                     in_run;
  logic                     in_drive;
  logic [ADC_BITS-1:0]      in_adc;
  logic [XW-1:0]            x_in;

  // arithmetic pieces
  logic signed [GAIN_W+DIG_W:0]  dig_prod;
  logic signed [AW-1:0]          acc_step;
  logic signed [XHW+GAIN_W-1:0]  hi_prod;
  logic signed [AW-1:0]          sat_in;
  logic signed [CUR_W-1:0]       s_sat;
  logic [SUM_W-1:0]              mag_full;
  logic [MAG_W-1:0]              mag;
  logic [CUR_W-1:0]              cur_new;
  logic signed [CUR_W:0]         nsum;
  logic [N_W+DIG_W-1:0]          np;
  logic [PROD_W-1:0]             rnd;

  // divider handshakes
  logic                     div10_start, div10_done;
  logic [DIV10_NUM_W-1:0]   div10_q;
  logic                     div2_start, div2_done;
  logic [DIV2_NUM_W-1:0]    div2_q;

  // ---------------------------------------------------------------------------
  // configuration port, writes land on the access cycle
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_comb begin
    case (cfg_idx)
      REG_GAIN:   prdata = 32'(unsigned'(gain_q));
      REG_OFFSET: prdata = 32'(unsigned'(offset_q));
      REG_PERIOD: prdata = 32'(period_q);
      REG_THRESH: prdata = 32'(thr_q);
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // input beat decode
  // ---------------------------------------------------------------------------
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign in_run        = s_axis_tdata[0];
  assign in_drive      = s_axis_tdata[1];
  assign in_adc        = s_axis_tdata[ADC_BITS+1:2];
  assign x_in          = XW'({in_adc, 1'b0}) - FullC;

  // ---------------------------------------------------------------------------
  // sample scaling: floor(x*gain/4096) with the low 12 bits of x taken one
  // digit a cycle (accumulate and shift right), then the signed high part
  // ---------------------------------------------------------------------------
  assign dig_prod = gain_q * $signed({1'b0, xl_q[DIG_W-1:0]});
  assign acc_step = (acc_q + AW'(dig_prod)) >>> DIG_W;
  assign hi_prod  = xh_q * gain_q;

  // offset and saturation to the 20-bit current range
  assign sat_in = acc_q + AW'(offset_q);
  always_comb begin
    if (sat_in < AW'(CUR_MIN)) begin
      s_sat = CUR_W'(CUR_MIN);
    end else if (sat_in > AW'(CUR_MAX)) begin
      s_sat = CUR_W'(CUR_MAX);
    end else begin
      s_sat = sat_in[CUR_W-1:0];
    end
  end

  // magnitude plus half the divisor, for round-half-away division by ten
  assign mag_full = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(6)) : (sum_q + SUM_W'(5));
  assign mag      = mag_full[MAG_W-1:0];

  // ---------------------------------------------------------------------------
  // compare mapping: n = clamp(cur + 68000), then (n*(period+1) + 68000)/136000
  // with the period digits fed msb first into the product
  // ---------------------------------------------------------------------------
  assign cur_new = loaded_q ? filt_q[FILT_W-1:4] : '0;
  assign nsum    = $signed({cur_new[CUR_W-1], cur_new}) + (CUR_W + 1)'(SPAN_HALF);
  assign np      = n_q * pm_q[PMUL_W-1 -: DIG_W];
  assign rnd     = acc2_q + PROD_W'(SPAN_HALF);

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    dcnt_d      = dcnt_q;
    loaded_d    = loaded_q;
    filt_d      = filt_q;
    xl_d        = xl_q;
    xh_d        = xh_q;
    acc_d       = acc_q;
    t9_d        = t9_q;
    s_d         = s_q;
    sum_d       = sum_q;
    cur_d       = cur_q;
    fire_d      = fire_q;
    n_d         = n_q;
    pm_d        = pm_q;
    acc2_d      = acc2_q;
    duty_d      = duty_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_data_d  = out_data_q;
    div10_start = 1'b0;
    div2_start  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          xl_d  = x_in[XL_W-1:0];
          xh_d  = x_in[XW-1:XL_W];
          acc_d = '0;
          if (!in_run) begin
            // waveform stopped: clear the filter, all-zero result
            loaded_d = 1'b0;
            filt_d   = '0;
            cur_d    = '0;
            fire_d   = 1'b0;
            duty_d   = '0;
            state_d  = S_DONE;
          end else if (in_drive) begin
            dcnt_d  = CNT_W'(XL_DIGITS - 1);
            state_d = S_MUL;
          end else begin
            state_d = S_CUR;
          end
        end
      end
      S_MUL: begin
        acc_d = acc_step;
        xl_d  = xl_q >> DIG_W;
        if (dcnt_q == '0) begin
          state_d = S_MULH;
        end else begin
          dcnt_d = dcnt_q - 1'b1;
        end
      end
      S_MULH: begin
        acc_d   = acc_q + AW'(hi_prod);
        t9_d    = (SUM_W'(filt_q) <<< 3) + SUM_W'(filt_q);
        state_d = S_SAT;
      end
      S_SAT: begin
        s_d = s_sat;
        if (!loaded_q) begin
          // first sample after start loads the filter directly
          filt_d   = {s_sat, 4'b0000};
          loaded_d = 1'b1;
          state_d  = S_CUR;
        end else begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        sum_d   = t9_q + (SUM_W'(s_q) <<< 4);
        state_d = S_ABS;
      end
      S_ABS: begin
        div10_start = 1'b1;
        state_d     = S_DIV10;
      end
      S_DIV10: begin
        if (div10_done) begin
          filt_d  = sum_q[SUM_W-1] ? (FILT_W'(0) - div10_q) : div10_q;
          state_d = S_CUR;
        end
      end
      S_CUR: begin
        cur_d  = cur_new;
        fire_d = $signed({cur_new[CUR_W-1], cur_new}) > $signed((CUR_W + 1)'(thr_q));
        if (nsum[CUR_W]) begin
          n_d = '0;
        end else if (nsum > (CUR_W + 1)'(SPAN_FULL)) begin
          n_d = N_W'(SPAN_FULL);
        end else begin
          n_d = nsum[N_W-1:0];
        end
        pm_d    = PMUL_W'(period_q) + 1'b1;
        acc2_d  = '0;
        dcnt_d  = CNT_W'(PMUL_DIGITS - 1);
        state_d = S_MUL2;
      end
      S_MUL2: begin
        acc2_d = (acc2_q << DIG_W) + PROD_W'(np);
        pm_d   = pm_q << DIG_W;
        if (dcnt_q == '0) begin
          state_d = S_RND;
        end else begin
          dcnt_d = dcnt_q - 1'b1;
        end
      end
      S_RND: begin
        div2_start = 1'b1;
        state_d    = S_DIV2;
      end
      S_DIV2: begin
        if (div2_done) begin
          duty_d  = (div2_q > PMUL_W'(period_q)) ? period_q : div2_q[PER_W-1:0];
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hand over once the output register is free or draining this cycle
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = OUT_W'({duty_q, fire_q, cur_q});
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // constant dividers
  // ---------------------------------------------------------------------------
  cpf_serial_div #(
    .NumW    (DIV10_NUM_W),
    .RemW    (DIV10_REM_W),
    .Divisor (FILT_DIV)
  ) u_div10 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div10_start),
    .num_i   (mag[DIV10_NUM_W-1:0]),
    .rem_i   (DIV10_REM_W'(mag[MAG_W-1:DIV10_NUM_W])),
    .done_o  (div10_done),
    .quot_o  (div10_q)
  );

  cpf_serial_div #(
    .NumW    (DIV2_NUM_W),
    .RemW    (DIV2_REM_W),
    .Divisor (SPAN_FULL)
  ) u_div2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div2_start),
    .num_i   (rnd[DIV2_NUM_W-1:0]),
    .rem_i   (DIV2_REM_W'(rnd[PROD_W-1:DIV2_NUM_W])),
    .done_o  (div2_done),
    .quot_o  (div2_q)
  );

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= '0;
      offset_q    <= '0;
      period_q    <= PER_W'(9999);
      thr_q       <= THR_W'(64000);
      state_q     <= S_IDLE;
      dcnt_q      <= '0;
      loaded_q    <= 1'b0;
      filt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          REG_GAIN:   gain_q   <= pwdata[GAIN_W-1:0];
          REG_OFFSET: offset_q <= pwdata[OFS_W-1:0];
          REG_PERIOD: period_q <= pwdata[PER_W-1:0];
          REG_THRESH: thr_q    <= pwdata[THR_W-1:0];
          default:    ;
        endcase
      end
      state_q     <= state_d;
      dcnt_q      <= dcnt_d;
      loaded_q    <= loaded_d;
      filt_q      <= filt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xl_q       <= xl_d;
    xh_q       <= xh_d;
    acc_q      <= acc_d;
    t9_q       <= t9_d;
    s_q        <= s_d;
    sum_q      <= sum_d;
    cur_q      <= cur_d;
    fire_q     <= fire_d;
    n_q        <= n_d;
    pm_q       <= pm_d;
    acc2_q     <= acc2_d;
    duty_q     <= duty_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // divider results only arrive while the sequencer waits for them
  a_div10_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div10_done |-> (state_q == S_DIV10))
    else $error("divide by ten finished outside its wait state");

  a_div2_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div2_done |-> (state_q == S_DIV2))
    else $error("compare divide finished outside its wait state");

  // an unloaded filter always reports zero current
  a_unloaded_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && !loaded_q) |-> (cur_q == '0))
    else $error("nonzero current reported from an unloaded filter");

  // a beat handed to the output register is visible the next cycle
  a_out_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && (!out_valid_q || m_axis_tready)) |=> m_axis_tvalid)
    else $error("finished beat not presented on the result stream");

endmodule
